// File: hw/rtl/lpw_pkg.sv
package lpw_pkg;

  // Screen size registers and colour components have fixed widths.
  localparam int SCREEN_BITS = 12;
  localparam int COLOR_BITS  = 8;

  // Operation carried by an input transaction.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_e;

  // Walk direction chosen at load time.
  typedef enum logic [1:0] {
    MODE_VERT = 2'd0,
    MODE_HORZ = 2'd1,
    MODE_RISE = 2'd2,
    MODE_FALL = 2'd3
  } walk_mode_e;

  // Control state of the walker, passed between the state registers and the step logic.
  typedef struct packed {
    logic       busy;
    walk_mode_e mode;
    logic       y_run;
  } walk_ctl_t;

endpackage

// File: hw/rtl/lpw_step.sv
module lpw_step #(
  parameter int CB = 12
) (
  input  logic                                 do_load_i,
  input  logic                                 do_step_i,
  input  logic signed [CB-1:0]                 x_start_i,
  input  logic signed [CB-1:0]                 y_start_i,
  input  logic signed [CB-1:0]                 x_end_i,
  input  logic signed [CB-1:0]                 y_end_i,
  input  logic [lpw_pkg::SCREEN_BITS-1:0]      screen_width_i,
  input  logic [lpw_pkg::SCREEN_BITS-1:0]      screen_height_i,
  input  lpw_pkg::walk_ctl_t                   ctl_i,
  input  logic signed [CB-1:0]                 cur_x_i,
  input  logic signed [CB:0]                   cur_y_i,
  input  logic signed [CB-1:0]                 tgt_x_i,
  input  logic signed [CB-1:0]                 tgt_y_i,
  input  logic signed [CB:0]                   span_x_i,
  input  logic signed [CB:0]                   span_y_i,
  input  logic signed [2*CB+1:0]               cross_x_i,
  input  logic signed [2*CB+1:0]               cross_y_i,
  output lpw_pkg::walk_ctl_t                   ctl_o,
  output logic signed [CB-1:0]                 cur_x_o,
  output logic signed [CB:0]                   cur_y_o,
  output logic signed [CB-1:0]                 tgt_x_o,
  output logic signed [CB-1:0]                 tgt_y_o,
  output logic signed [CB:0]                   span_x_o,
  output logic signed [CB:0]                   span_y_o,
  output logic signed [2*CB+1:0]               cross_x_o,
  output logic signed [2*CB+1:0]               cross_y_o,
  output logic                                 res_valid_o,
  output logic signed [CB-1:0]                 res_x_o,
  output logic signed [CB-1:0]                 res_y_o,
  output logic                                 res_on_screen_o,
  output logic                                 res_last_o
);
  import lpw_pkg::*;

  localparam int PW = 2 * CB + 2;
  localparam int CW = (CB + 2 > SCREEN_BITS + 1) ? CB + 2 : SCREEN_BITS + 1;
  localparam logic signed [CB-1:0] X_ONE = CB'(1);
  localparam logic signed [CB:0]   Y_ONE = (CB + 1)'(1);

  logic                   swap;
  logic signed [CB-1:0]   x1, y1, x2, y2;
  logic signed [CB:0]     sx_ld, sy_ld;
  logic signed [CB:0]     tgt_y_ext;
  logic signed [PW-1:0]   sx_ext, sy_ext;
  logic signed [CB-1:0]   x_inc;
  logic signed [CB:0]     y_move;
  logic signed [PW-1:0]   ax_inc, ay_move;
  logic                   rise;
  logic                   run_on;
  logic                   x_ok, y_ok;
  logic                   last;

  // Load path: order the endpoints so that x never falls, then take the spans.
  assign swap  = x_end_i < x_start_i;
  assign x1    = swap ? x_end_i : x_start_i;
  assign y1    = swap ? y_end_i : y_start_i;
  assign x2    = swap ? x_start_i : x_end_i;
  assign y2    = swap ? y_start_i : y_end_i;
  assign sx_ld = {x2[CB-1], x2} - {x1[CB-1], x1};
  assign sy_ld = {y2[CB-1], y2} - {y1[CB-1], y1};

  // Step path: one incremental update of a cross-product term per step.
  assign tgt_y_ext = {tgt_y_i[CB-1], tgt_y_i};
  assign sx_ext    = {{(PW-CB-1){span_x_i[CB]}}, span_x_i};
  assign sy_ext    = {{(PW-CB-1){span_y_i[CB]}}, span_y_i};
  assign rise      = ctl_i.mode == MODE_RISE;
  assign x_inc     = cur_x_i + X_ONE;
  assign y_move    = span_y_i[CB] ? cur_y_i - Y_ONE : cur_y_i + Y_ONE;
  assign ax_inc    = cross_x_i + sy_ext;
  assign ay_move   = rise ? cross_y_i + sx_ext : cross_y_i - sx_ext;

  // Next state and result flags.
  always_comb begin
    ctl_o     = ctl_i;
    cur_x_o   = cur_x_i;
    cur_y_o   = cur_y_i;
    tgt_x_o   = tgt_x_i;
    tgt_y_o   = tgt_y_i;
    span_x_o  = span_x_i;
    span_y_o  = span_y_i;
    cross_x_o = cross_x_i;
    cross_y_o = cross_y_i;
    last      = 1'b0;
    run_on    = 1'b0;

    if (do_load_i) begin
      cur_x_o     = x1;
      cur_y_o     = {y1[CB-1], y1};
      tgt_x_o     = x2;
      tgt_y_o     = y2;
      span_x_o    = sx_ld;
      span_y_o    = sy_ld;
      cross_x_o   = '0;
      cross_y_o   = '0;
      ctl_o.busy  = 1'b1;
      ctl_o.y_run = 1'b0;
      if (sx_ld == '0) begin
        ctl_o.mode = MODE_VERT;
      end else if (sy_ld == '0) begin
        ctl_o.mode = MODE_HORZ;
      end else if (!sy_ld[CB]) begin
        ctl_o.mode = MODE_RISE;
      end else begin
        ctl_o.mode = MODE_FALL;
      end
    end else if (do_step_i && ctl_i.busy) begin
      case (ctl_i.mode)
        MODE_VERT: begin
          if (cur_y_i == tgt_y_ext) begin
            last = 1'b1;
          end else begin
            cur_y_o = y_move;
          end
        end
        MODE_HORZ: begin
          if (cur_x_i >= tgt_x_i) begin
            last = 1'b1;
          end else begin
            cur_x_o = x_inc;
          end
        end
        default: begin
          if (!ctl_i.y_run) begin
            // Run along x while the pixel stays on the near side of the line.
            cur_x_o   = x_inc;
            cross_x_o = ax_inc;
            run_on    = (rise ? (ax_inc < cross_y_i) : (ax_inc > cross_y_i))
                        && (x_inc < tgt_x_i);
            if (!run_on) begin
              ctl_o.y_run = 1'b1;
            end
          end else begin
            // Run along y while the pixel stays on the far side of the line.
            cur_y_o   = rise ? cur_y_i + Y_ONE : cur_y_i - Y_ONE;
            cross_y_o = ay_move;
            run_on    = (rise ? (cross_x_i > ay_move) : (cross_x_i < ay_move))
                        && (rise ? (cur_y_o < tgt_y_ext) : (cur_y_o > tgt_y_ext));
            if (!run_on) begin
              if (cur_x_i < tgt_x_i) begin
                ctl_o.y_run = 1'b0;
              end else begin
                last = 1'b1;
              end
            end
          end
        end
      endcase
      if (last) begin
        ctl_o.busy = 1'b0;
      end
    end
  end

  // Result fields come from the position before the update.
  assign x_ok = !cur_x_i[CB-1] &&
                ({{(CW-CB){1'b0}}, cur_x_i} < {{(CW-SCREEN_BITS){1'b0}}, screen_width_i});
  assign y_ok = !cur_y_i[CB] &&
                ({{(CW-CB-1){1'b0}}, cur_y_i} < {{(CW-SCREEN_BITS){1'b0}}, screen_height_i});

  assign res_valid_o     = do_step_i && ctl_i.busy;
  assign res_x_o         = cur_x_i;
  assign res_y_o         = cur_y_i[CB-1:0];
  assign res_on_screen_o = x_ok && y_ok;
  assign res_last_o      = last;

endmodule

// File: hw/rtl/lpw_out.sv
module lpw_out #(
  parameter int CB = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [CB-1:0]                x_i,
  input  logic signed [CB-1:0]                y_i,
  input  logic [3*lpw_pkg::COLOR_BITS-1:0]    colour_i,
  input  logic                                on_screen_i,
  input  logic                                last_i,
  input  logic                                ready_i,
  output logic                                valid_o,
  output logic signed [CB-1:0]                x_o,
  output logic signed [CB-1:0]                y_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]      red_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]      green_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]      blue_o,
  output logic                                on_screen_o,
  output logic                                last_o
);
  import lpw_pkg::*;

  logic                        valid_q, valid_d;
  logic signed [CB-1:0]        x_q, y_q;
  logic [3*COLOR_BITS-1:0]     colour_q;
  logic                        on_screen_q, last_q;

  // A new result replaces one that is being taken in the same cycle.
  always_comb begin
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload is loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      x_q         <= x_i;
      y_q         <= y_i;
      colour_q    <= colour_i;
      on_screen_q <= on_screen_i;
      last_q      <= last_i;
    end
  end

  assign valid_o     = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign red_o       = colour_q[3*COLOR_BITS-1:2*COLOR_BITS];
  assign green_o     = colour_q[2*COLOR_BITS-1:COLOR_BITS];
  assign blue_o      = colour_q[COLOR_BITS-1:0];
  assign on_screen_o = on_screen_q;
  assign last_o      = last_q;

endmodule

// File: hw/rtl/line_pixel_walker.sv
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_ready_o  | operation, endpoints, colour
// output  | out       | out_valid_o / out_ready_i| pixel position, colour, flags
// config  | in        | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
// Each input transaction is handled as it is accepted; a step produces its pixel
// in the output register on the next cycle, so one pixel per clock is sustained
// while results are taken. The rate is set by the combinational state update: one
// incremental add and one compare on a cross-product term per step.
// Reset clears the walker to idle and the screen size to 640 by 480.
// The input is stalled only while a result is held and not taken.
module line_pixel_walker #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_addr_i,
  input  logic [lpw_pkg::SCREEN_BITS-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic signed [COORD_BITS-1:0]         x_start_i,
  input  logic signed [COORD_BITS-1:0]         y_start_i,
  input  logic signed [COORD_BITS-1:0]         x_end_i,
  input  logic signed [COORD_BITS-1:0]         y_end_i,
  input  logic [lpw_pkg::COLOR_BITS-1:0]       red_i,
  input  logic [lpw_pkg::COLOR_BITS-1:0]       green_i,
  input  logic [lpw_pkg::COLOR_BITS-1:0]       blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_BITS-1:0]         pixel_x_o,
  output logic signed [COORD_BITS-1:0]         pixel_y_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]       pixel_red_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]       pixel_green_o,
  output logic [lpw_pkg::COLOR_BITS-1:0]       pixel_blue_o,
  output logic                                 on_screen_o,
  output logic                                 last_pixel_o
);
  import lpw_pkg::*;

  localparam int CB = COORD_BITS;

  logic                      accept, do_load, do_step;
  logic [SCREEN_BITS-1:0]    width_q, height_q;
  walk_ctl_t                 ctl_q, ctl_d;
  logic signed [CB-1:0]      cur_x_q, cur_x_d, tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic signed [CB:0]        cur_y_q, cur_y_d, span_x_q, span_x_d, span_y_q, span_y_d;
  logic signed [2*CB+1:0]    cross_x_q, cross_x_d, cross_y_q, cross_y_d;
  logic [3*COLOR_BITS-1:0]   colour_q;
  logic                      res_valid, res_on_screen, res_last;
  logic signed [CB-1:0]      res_x, res_y;

  // Input handshake: the output register frees up when its result is taken.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign do_load    = accept && (operation_i == OP_LOAD);
  assign do_step    = accept && (operation_i == OP_STEP);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_BITS'(640);
      height_q <= SCREEN_BITS'(480);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_SCREEN_WIDTH) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_addr_i == REG_SCREEN_HEIGHT) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  // Walker state, updated on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q     <= '{busy: 1'b0, mode: MODE_VERT, y_run: 1'b0};
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      span_x_q  <= '0;
      span_y_q  <= '0;
      cross_x_q <= '0;
      cross_y_q <= '0;
      colour_q  <= '0;
    end else if (accept) begin
      ctl_q     <= ctl_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      tgt_x_q   <= tgt_x_d;
      tgt_y_q   <= tgt_y_d;
      span_x_q  <= span_x_d;
      span_y_q  <= span_y_d;
      cross_x_q <= cross_x_d;
      cross_y_q <= cross_y_d;
      if (do_load) begin
        colour_q <= {red_i, green_i, blue_i};
      end
    end
  end

  lpw_step #(.CB(CB)) u_step (
    .do_load_i       (do_load),
    .do_step_i       (do_step),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .screen_width_i  (width_q),
    .screen_height_i (height_q),
    .ctl_i           (ctl_q),
    .cur_x_i         (cur_x_q),
    .cur_y_i         (cur_y_q),
    .tgt_x_i         (tgt_x_q),
    .tgt_y_i         (tgt_y_q),
    .span_x_i        (span_x_q),
    .span_y_i        (span_y_q),
    .cross_x_i       (cross_x_q),
    .cross_y_i       (cross_y_q),
    .ctl_o           (ctl_d),
    .cur_x_o         (cur_x_d),
    .cur_y_o         (cur_y_d),
    .tgt_x_o         (tgt_x_d),
    .tgt_y_o         (tgt_y_d),
    .span_x_o        (span_x_d),
    .span_y_o        (span_y_d),
    .cross_x_o       (cross_x_d),
    .cross_y_o       (cross_y_d),
    .res_valid_o     (res_valid),
    .res_x_o         (res_x),
    .res_y_o         (res_y),
    .res_on_screen_o (res_on_screen),
    .res_last_o      (res_last)
  );

  lpw_out #(.CB(CB)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .x_i         (res_x),
    .y_i         (res_y),
    .colour_i    (colour_q),
    .on_screen_i (res_on_screen),
    .last_i      (res_last),
    .ready_i     (out_ready_i),
    .valid_o     (out_valid_o),
    .x_o         (pixel_x_o),
    .y_o         (pixel_y_o),
    .red_o       (pixel_red_o),
    .green_o     (pixel_green_o),
    .blue_o      (pixel_blue_o),
    .on_screen_o (on_screen_o),
    .last_o      (last_pixel_o)
  );

endmodule

// File: hw/rtl/lpw_checker.sv
module lpw_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 operation_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [COORD_BITS-1:0]         pixel_x_o,
  input logic signed [COORD_BITS-1:0]         pixel_y_o,
  input logic                                 on_screen_o
);
  import lpw_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its position.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_x_o) && $stable(pixel_y_o))
    else $error("result changed while stalled");

  // A load transaction never produces a pixel.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && operation_i == OP_LOAD |=> !out_valid_o)
    else $error("load produced a pixel");

  // The first step after a load always yields a pixel.
  a_first_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(in_acc && operation_i == OP_LOAD) &&
    in_acc && operation_i == OP_STEP |=> out_valid_o)
    else $error("first step after load gave no pixel");

  // A negative x can never be reported on screen.
  a_clip_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_x_o[COORD_BITS-1] |-> !on_screen_o)
    else $error("negative x reported on screen");

endmodule

bind line_pixel_walker lpw_checker #(.COORD_BITS(COORD_BITS)) u_lpw_checker (.*);
